@@ rtl/core/stks_pkg.sv @@
// ----------------------------------------------------------------------------
// stks_pkg: shared types and constants of the streaming top-k sum unit
// Holds the fixed field widths, the keep register reset value and the
// broadcast control word that steers every cell of the sorted chain.
// ----------------------------------------------------------------------------
package stks_pkg;

  localparam int SUM_W  = 22;
  localparam int KEEP_W = 7;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd1;

  // Operation broadcast to all cells for one transaction
  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,
    OP_INSERT  = 2'd1,
    OP_REPLACE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     clear;
  } cell_ctl_t;

endpackage

@@ rtl/core/stks_in_if.sv @@
// ----------------------------------------------------------------------------
// stks_in_if: sample channel
// Valid/ready channel carrying one stream element and its framing marks.
// ----------------------------------------------------------------------------
interface stks_in_if #(
  parameter int VALUE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] sample_value;
  logic                  first_item;
  logic                  last_item;

  modport source (output valid, output sample_value, output first_item,
                  output last_item, input ready);
  modport sink   (input valid, input sample_value, input first_item,
                  input last_item, output ready);
endinterface

@@ rtl/core/stks_out_if.sv @@
// ----------------------------------------------------------------------------
// stks_out_if: result channel
// Valid/ready channel carrying the running top-k sum and the final mark.
// ----------------------------------------------------------------------------
interface stks_out_if;
  logic                       valid;
  logic                       ready;
  logic [stks_pkg::SUM_W-1:0] top_sum;
  logic                       final_res;

  modport source (output valid, output top_sum, output final_res, input ready);
  modport sink   (input valid, input top_sum, input final_res, output ready);
endinterface

@@ rtl/core/stks_cfg_if.sv @@
// ----------------------------------------------------------------------------
// stks_cfg_if: configuration write channel
// Valid/ready channel carrying the keep count register value.
// ----------------------------------------------------------------------------
interface stks_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [stks_pkg::KEEP_W-1:0] keep_count;

  modport source (output valid, output keep_count, input ready);
  modport sink   (input valid, input keep_count, output ready);
endinterface

@@ rtl/core/stks_cell.sv @@
// ----------------------------------------------------------------------------
// stks_cell: one slot of the sorted keep chain
// Holds one kept value and its valid bit. Compares against the broadcast
// sample and takes its own, its neighbor's or the new value.
// ----------------------------------------------------------------------------
module stks_cell #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stks_pkg::cell_ctl_t ctl_i,
  input  logic [W-1:0]        val_i,
  input  logic [W-1:0]        left_value_i,
  input  logic                left_ge_i,
  input  logic                left_valid_i,
  input  logic [W-1:0]        right_value_i,
  input  logic                right_lt_i,
  output logic [W-1:0]        value_o,
  output logic                valid_o,
  output logic                ge_o,
  output logic                lt_o
);

  logic [W-1:0] value_r, value_nxt;
  logic         valid_r, valid_nxt;
  logic         valid_eff;

  assign valid_eff = valid_r & ~ctl_i.clear;
  assign ge_o      = ~valid_eff | (value_r > val_i);
  assign lt_o      = valid_eff & (value_r < val_i);
  assign value_o   = value_r;
  assign valid_o   = valid_eff;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_eff;
    case (ctl_i.op)
      stks_pkg::OP_INSERT: begin
        // shift larger values up one slot, drop the sample into the gap
        if (ge_o) begin
          value_nxt = left_ge_i ? left_value_i : val_i;
        end
        valid_nxt = valid_eff | left_valid_i;
      end
      stks_pkg::OP_REPLACE: begin
        // evict the minimum: smaller values move down, sample fills the gap
        if (right_lt_i) begin
          value_nxt = right_value_i;
        end else if (lt_o) begin
          value_nxt = val_i;
        end
      end
      default: begin
        value_nxt = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

@@ rtl/core/streaming_top_k_sum_unit.sv @@
// ----------------------------------------------------------------------------
// streaming_top_k_sum_unit: running sum of the k largest stream values
// Keeps the keep_count largest samples since the last restart in a sorted
// chain of cells and reports their sum for every sample.
// ----------------------------------------------------------------------------
// The unit takes one sample transaction per clock cycle and returns one
// result transaction for each, in the cycle after acceptance, through an
// output register; in_chan.ready is high whenever that register is empty or
// being drained. The kept values live in a chain of MAX_KEEP cells sorted
// ascending, so the smallest kept value is always in the first cell; each
// sample is broadcast to every cell, which either inserts it at its sorted
// place (while fewer than keep_count values are kept) or evicts the minimum
// and slides it in, all in the same cycle. A sample with first_item set
// restarts the stream before it is taken. keep_count above MAX_KEEP acts as
// MAX_KEEP; lowering it mid-stream keeps what is already held. No clearing
// pass is needed after reset: reset clears the cell valid bits at once.
// Write cfg_chan only while no result is outstanding.
// ----------------------------------------------------------------------------
module streaming_top_k_sum_unit #(
  parameter int MAX_KEEP   = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  stks_in_if.sink     in_chan,
  stks_out_if.source  out_chan,
  stks_cfg_if.sink    cfg_chan
);

  localparam int CNT_W = $clog2(MAX_KEEP + 1);
  localparam int CMP_W = (CNT_W > stks_pkg::KEEP_W) ? CNT_W : stks_pkg::KEEP_W;
  localparam int ADD_W = (stks_pkg::SUM_W > VALUE_BITS) ? stks_pkg::SUM_W : VALUE_BITS;

  // Configuration register, always writable
  logic [stks_pkg::KEEP_W-1:0] keep_count_r;

  // Stream state
  logic [CNT_W-1:0]           count_r, count_nxt, count_eff;
  logic [stks_pkg::SUM_W-1:0] sum_r, sum_nxt, sum_base;

  // Output register
  logic                       out_valid_r;
  logic [stks_pkg::SUM_W-1:0] out_sum_r;
  logic                       out_final_r;

  logic                accept;
  logic [CMP_W-1:0]    limit;
  logic                do_insert, do_replace;
  logic [VALUE_BITS-1:0] delta;
  stks_pkg::cell_ctl_t ctl;

  // Chain wiring
  logic [VALUE_BITS-1:0] cell_value [MAX_KEEP];
  logic                  cell_valid [MAX_KEEP];
  logic                  cell_ge    [MAX_KEEP];
  logic                  cell_lt    [MAX_KEEP];

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= stks_pkg::KEEP_RESET;
    end else if (cfg_chan.valid) begin
      keep_count_r <= cfg_chan.keep_count;
    end
  end

  // Take a new sample whenever the output register is free or draining
  assign in_chan.ready = ~out_valid_r | out_chan.ready;
  assign accept        = in_chan.valid & in_chan.ready;

  // Saturate the keep limit at the chain length
  always_comb begin
    if (CMP_W'(keep_count_r) > CMP_W'(MAX_KEEP)) begin
      limit = CMP_W'(MAX_KEEP);
    end else begin
      limit = CMP_W'(keep_count_r);
    end
  end

  assign count_eff = (in_chan.first_item) ? '0 : count_r;
  assign sum_base  = (in_chan.first_item) ? '0 : sum_r;

  // Insert while below the limit; otherwise replace the minimum if beaten.
  // cell_valid[0] already reflects a restart, so it tells if anything is kept.
  assign do_insert  = accept & (CMP_W'(count_eff) < limit);
  assign do_replace = accept & ~do_insert & cell_valid[0]
                    & (in_chan.sample_value > cell_value[0]);

  always_comb begin
    ctl.clear = accept & in_chan.first_item;
    if (do_insert) begin
      ctl.op = stks_pkg::OP_INSERT;
    end else if (do_replace) begin
      ctl.op = stks_pkg::OP_REPLACE;
    end else begin
      ctl.op = stks_pkg::OP_HOLD;
    end
  end

  // Sum moves by the sample on insert, by sample minus minimum on replace
  assign delta = do_insert ? in_chan.sample_value
                           : (in_chan.sample_value - cell_value[0]);

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (accept) begin
      count_nxt = do_insert ? (count_eff + CNT_W'(1)) : count_eff;
      if (do_insert || do_replace) begin
        sum_nxt = stks_pkg::SUM_W'(ADD_W'(sum_base) + ADD_W'(delta));
      end else begin
        sum_nxt = sum_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result payload until the next accepted sample
  always_ff @(posedge clk) begin
    if (accept) begin
      out_sum_r   <= sum_nxt;
      out_final_r <= in_chan.last_item;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.top_sum   = out_sum_r;
  assign out_chan.final_res = out_final_r;

  // Sorted chain: cell 0 holds the minimum
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_value, right_value;
    logic                  left_ge, left_valid, right_lt;

    if (i == 0) begin : g_head
      assign left_value = '0;
      assign left_ge    = 1'b0;
      assign left_valid = 1'b1;
    end else begin : g_mid
      assign left_value = cell_value[i-1];
      assign left_ge    = cell_ge[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign right_value = '0;
      assign right_lt    = 1'b0;
    end else begin : g_body
      assign right_value = cell_value[i+1];
      assign right_lt    = cell_lt[i+1];
    end

    stks_cell #(
      .W (VALUE_BITS)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl_i         (ctl),
      .val_i         (in_chan.sample_value),
      .left_value_i  (left_value),
      .left_ge_i     (left_ge),
      .left_valid_i  (left_valid),
      .right_value_i (right_value),
      .right_lt_i    (right_lt),
      .value_o       (cell_value[i]),
      .valid_o       (cell_valid[i]),
      .ge_o          (cell_ge[i]),
      .lt_o          (cell_lt[i])
    );
  end

  // Kept count never exceeds the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(MAX_KEEP))
    else $error("kept count beyond chain length");

  // State moves only on an accepted sample
  a_sum_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(sum_r) && $stable(count_r))
    else $error("stream state changed without a transaction");

  // Every accepted sample leaves a result pending
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted sample produced no result");

  // Insert and replace are never issued together
  a_op_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_insert && do_replace))
    else $error("insert and replace both active");

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the streaming top-k sum unit
// Drives sample streams through the unit under several keep counts and
// traffic patterns. A behavioral model of the top-k selection predicts the
// unpinned results, and a scoreboard compares each result with what the unit sends.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_KEEP   = 64;
  localparam int VALUE_BITS = 16;

  // Run shape: 12 random phases of at least 135 samples each
  localparam int PHASES            = 12;
  localparam int PER_PHASE         = 135;
  localparam int RANDOM_KEEP_PHASE = 9;
  // The longest quiet stretch in a correct run is made of random stalls plus
  // the drain before each keep write; this is many times that.
  localparam int QUIET_LIMIT       = 5000;

  typedef logic [VALUE_BITS-1:0] sample_t;

  typedef enum logic [1:0] {
    IDLE_NONE = 2'd0,
    IDLE_SEND = 2'd1,
    IDLE_RECV = 2'd2,
    IDLE_BOTH = 2'd3
  } idle_mode_t;

  typedef enum logic [1:0] {
    MIX_FULL = 2'd0,
    MIX_TINY = 2'd1,
    MIX_HIGH = 2'd2,
    MIX_PEAK = 2'd3
  } value_mix_t;

  typedef enum logic {
    ROW_SAMPLE = 1'b0,
    ROW_KEEP   = 1'b1
  } row_kind_t;

  // One directed row: either a sample or a keep write (value carries the keep).
  // When pinned is set, sum is the known answer for that sample.
  typedef struct packed {
    row_kind_t                  kind;
    sample_t                    value;
    logic                       first;
    logic                       last;
    logic                       pinned;
    logic [stks_pkg::SUM_W-1:0] sum;
  } dir_row_t;

  typedef struct packed {
    logic [stks_pkg::SUM_W-1:0] top_sum;
    logic                       final_res;
  } sum_result_t;

  localparam int DIR_N = 26;
  localparam dir_row_t DIRECTED_ROWS [DIR_N] = '{
    // keep = 1 after reset: zero, then the max replaces it, smaller one does not
    '{ROW_SAMPLE, 16'd0,     1'b0, 1'b0, 1'b1, 22'd0},
    '{ROW_SAMPLE, 16'd65535, 1'b0, 1'b0, 1'b1, 22'd65535},
    '{ROW_SAMPLE, 16'd100,   1'b0, 1'b1, 1'b1, 22'd65535},
    '{ROW_SAMPLE, 16'd7,     1'b1, 1'b0, 1'b1, 22'd7},
    // largest keep: values accumulate
    '{ROW_KEEP,   16'd64,    1'b0, 1'b0, 1'b0, 22'd0},
    '{ROW_SAMPLE, 16'd65535, 1'b1, 1'b0, 1'b1, 22'd65535},
    '{ROW_SAMPLE, 16'd65535, 1'b0, 1'b0, 1'b1, 22'd131070},
    '{ROW_SAMPLE, 16'd0,     1'b0, 1'b1, 1'b1, 22'd131070},
    // keep zero: held values still get replaced, a fresh stream is ignored
    '{ROW_KEEP,   16'd0,     1'b0, 1'b0, 1'b0, 22'd0},
    '{ROW_SAMPLE, 16'd40000, 1'b0, 1'b0, 1'b0, 22'd0},
    '{ROW_SAMPLE, 16'd9,     1'b1, 1'b0, 1'b1, 22'd0},
    '{ROW_SAMPLE, 16'd65535, 1'b0, 1'b1, 1'b1, 22'd0},
    // keep above the chain depth acts as the depth
    '{ROW_KEEP,   16'd127,   1'b0, 1'b0, 1'b0, 22'd0},
    '{ROW_SAMPLE, 16'd3,     1'b1, 1'b0, 1'b1, 22'd3},
    '{ROW_SAMPLE, 16'd65535, 1'b0, 1'b0, 1'b1, 22'd65538},
    // keep 3: fill, reject a small one, replace the minimum, tie keeps old
    '{ROW_KEEP,   16'd3,     1'b0, 1'b0, 1'b0, 22'd0},
    '{ROW_SAMPLE, 16'd10,    1'b1, 1'b0, 1'b1, 22'd10},
    '{ROW_SAMPLE, 16'd20,    1'b0, 1'b0, 1'b1, 22'd30},
    '{ROW_SAMPLE, 16'd30,    1'b0, 1'b0, 1'b1, 22'd60},
    '{ROW_SAMPLE, 16'd5,     1'b0, 1'b0, 1'b1, 22'd60},
    '{ROW_SAMPLE, 16'd40,    1'b0, 1'b0, 1'b1, 22'd90},
    '{ROW_SAMPLE, 16'd20,    1'b0, 1'b0, 1'b0, 22'd0},
    // keep lowered mid-stream: all three held values stay
    '{ROW_KEEP,   16'd2,     1'b0, 1'b0, 1'b0, 22'd0},
    '{ROW_SAMPLE, 16'd50,    1'b0, 1'b0, 1'b0, 22'd0},
    '{ROW_SAMPLE, 16'd1,     1'b0, 1'b1, 1'b0, 22'd0},
    '{ROW_SAMPLE, 16'd0,     1'b1, 1'b1, 1'b1, 22'd0}
  };

  // Keep counts per random phase; the extremes and over-range values included
  localparam logic [stks_pkg::KEEP_W-1:0] KEEP_PLAN [PHASES] = '{
    7'd64, 7'd1, 7'd127, 7'd4, 7'd0, 7'd17, 7'd64, 7'd2, 7'd9, 7'd0, 7'd33, 7'd100
  };

  logic clk;
  logic rst_n;

  stks_in_if #(.VALUE_BITS(VALUE_BITS)) in_chan ();
  stks_out_if                           out_chan ();
  stks_cfg_if                           cfg_chan ();

  streaming_top_k_sum_unit #(
    .MAX_KEEP  (MAX_KEEP),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  // Model state of the top-k selection, starting from the reset state
  sample_t                     held_vals [MAX_KEEP];
  logic [stks_pkg::KEEP_W-1:0] held_n   = '0;
  logic [stks_pkg::SUM_W-1:0]  held_sum = '0;
  logic [stks_pkg::KEEP_W-1:0] keep_reg = stks_pkg::KEEP_RESET;

  // Scoreboard: results predicted for accepted samples, oldest first
  sum_result_t pending_sums [$];

  // Known answer for the sample on the bus, driven alongside its payload
  logic                       pin_valid;
  logic [stks_pkg::SUM_W-1:0] pin_sum;

  idle_mode_t idle_mode;
  int         mismatches   = 0;
  int         samples_seen = 0;
  int         results_seen = 0;
  int         finals_seen  = 0;
  int         keep_writes  = 0;
  int         random_sent;
  int         quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the model by one sample and return the new running sum.
  function automatic logic [stks_pkg::SUM_W-1:0] advance_top_sum(sample_t v, logic first);
    int lim;
    int lo;
    lim = (keep_reg > MAX_KEEP) ? MAX_KEEP : int'(keep_reg);
    // Restart: drop everything held before taking this sample
    if (first) begin
      held_n   = '0;
      held_sum = '0;
    end
    if (int'(held_n) < lim) begin
      held_vals[held_n] = v;
      held_n            = held_n + 1'b1;
      held_sum          = held_sum + v;
    end else if (held_n != 0) begin
      // Full (or keep lowered below the fill): only a strictly larger sample
      // evicts the current minimum
      lo = 0;
      for (int i = 1; i < int'(held_n); i++) begin
        if (held_vals[i] < held_vals[lo]) lo = i;
      end
      if (v > held_vals[lo]) begin
        held_sum      = held_sum + (v - held_vals[lo]);
        held_vals[lo] = v;
      end
    end
    return held_sum;
  endfunction

  // Monitor: update the model on every accepted transaction, check every result.
  always @(posedge clk) begin : monitor
    sum_result_t want;
    sum_result_t got;
    logic [stks_pkg::SUM_W-1:0] model_sum;
    if (rst_n) begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        keep_reg = cfg_chan.keep_count;
        keep_writes++;
      end
      // Enqueue before dequeue so a same-edge result would still find its entry
      if (in_chan.valid && in_chan.ready) begin
        model_sum      = advance_top_sum(in_chan.sample_value, in_chan.first_item);
        want.top_sum   = pin_valid ? pin_sum : model_sum;
        want.final_res = in_chan.last_item;
        pending_sums   = {pending_sums, want};
        samples_seen++;
      end
      if (out_chan.valid && out_chan.ready) begin
        got.top_sum   = out_chan.top_sum;
        got.final_res = out_chan.final_res;
        results_seen++;
        if (got.final_res) finals_seen++;
        if (pending_sums.size() == 0) begin
          $display("%0t: unexpected result, expected none actual top_sum %0d final_res %0b",
                   $time, got.top_sum, got.final_res);
          mismatches++;
        end else begin
          want = pending_sums.pop_front();
          if (got.top_sum !== want.top_sum) begin
            $display("%0t: top_sum expected %0d actual %0d",
                     $time, want.top_sum, got.top_sum);
            mismatches++;
          end
          if (got.final_res !== want.final_res) begin
            $display("%0t: final_res expected %0b actual %0b",
                     $time, want.final_res, got.final_res);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver: stall at random according to the current idle mode.
  always @(posedge clk) begin : receiver
    int pct;
    pct = (idle_mode == IDLE_RECV) ? 46 : (idle_mode == IDLE_BOTH) ? 14 : 0;
    out_chan.ready <= !(int'($urandom_range(99)) < pct);
  end

  // Watchdog: end the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, pending_sums.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Present one sample and hold it until the unit takes the transaction.
  // Valid stays high on return so back-to-back samples need no gap.
  task automatic send_sample(input sample_t v, input logic first, input logic last,
                             input logic pin, input logic [stks_pkg::SUM_W-1:0] psum);
    int pct;
    pct = (idle_mode == IDLE_SEND) ? 46 : (idle_mode == IDLE_BOTH) ? 14 : 0;
    while (int'($urandom_range(99)) < pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.sample_value <= v;
    in_chan.first_item   <= first;
    in_chan.last_item    <= last;
    pin_valid            <= pin;
    pin_sum              <= psum;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    // Cover the output register stage
    repeat (2) @(posedge clk);
  endtask

  // Write the keep register; the unit must be idle first.
  task automatic write_keep(input logic [stks_pkg::KEEP_W-1:0] k);
    drain_results();
    cfg_chan.valid      <= 1'b1;
    cfg_chan.keep_count <= k;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
  endtask

  // One well-formed stream: first mark on the opening sample, last on the closing.
  task automatic send_stream(input int len, input value_mix_t mix);
    sample_t v;
    for (int i = 0; i < len; i++) begin
      case (mix)
        MIX_FULL: v = sample_t'($urandom);
        MIX_TINY: v = sample_t'($urandom_range(15));
        MIX_HIGH: v = sample_t'(16'hFFFF - $urandom_range(255));
        default:  v = '1;
      endcase
      send_sample(v, i == 0, i == len - 1, 1'b0, '0);
    end
    random_sent += len;
  endtask

  initial begin : stimulus
    logic [stks_pkg::KEEP_W-1:0] keep_pick;
    int lim;
    int phase_start;
    int lost;

    // Drive every input to a known value before the first edge
    in_chan.valid        <= 1'b0;
    in_chan.sample_value <= '0;
    in_chan.first_item   <= 1'b0;
    in_chan.last_item    <= 1'b0;
    cfg_chan.valid       <= 1'b0;
    cfg_chan.keep_count  <= '0;
    pin_valid            <= 1'b0;
    pin_sum              <= '0;
    idle_mode   = IDLE_NONE;
    random_sent = 0;
    lost        = 0;

    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: light traffic gaps on both sides
    idle_mode = IDLE_BOTH;
    for (int r = 0; r < DIR_N; r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_KEEP) begin
        write_keep(DIRECTED_ROWS[r].value[stks_pkg::KEEP_W-1:0]);
      end else begin
        send_sample(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].first,
                    DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].pinned,
                    DIRECTED_ROWS[r].sum);
      end
    end

    // Random phases: rotate the idle mode, change keep between phases
    for (int p = 0; p < PHASES; p++) begin
      keep_pick = (p == RANDOM_KEEP_PHASE)
                ? stks_pkg::KEEP_W'($urandom_range(1, MAX_KEEP))
                : KEEP_PLAN[p];
      write_keep(keep_pick);
      idle_mode = idle_mode_t'(p % 4);
      lim = (keep_pick > MAX_KEEP) ? MAX_KEEP : int'(keep_pick);
      if (lim == 0) lim = 8;
      phase_start = random_sent;

      // Open with a stream of peak values long enough to fill every kept slot,
      // which drives the sum to its maximum at the largest keep
      send_stream(lim + 4, MIX_PEAK);
      // Hold off the sender until the unit has answered everything
      drain_results();

      while (random_sent - phase_start < PER_PHASE) begin
        if ($urandom_range(99) < 85) begin
          send_stream($urandom_range(1, 2 * lim + 8), value_mix_t'($urandom_range(3)));
        end else begin
          // Noise: lone sample with arbitrary framing marks
          send_sample(sample_t'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'b0, '0);
          random_sent++;
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (pending_sums.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_sums.size());
      lost = pending_sums.size();
    end

    $display("Ran %0d samples (%0d results, %0d stream ends) across %0d keep writes,",
             samples_seen, results_seen, finals_seen, keep_writes);
    $display("with keep counts from 0 to 127 and four sender/receiver gap patterns.");
    if (mismatches == 0 && lost == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/stks_pkg.sv
rtl/core/stks_in_if.sv
rtl/core/stks_out_if.sv
rtl/core/stks_cfg_if.sv
rtl/core/stks_cell.sv
rtl/core/streaming_top_k_sum_unit.sv
test/tb_top.sv
